// ===== rtl/ihsq_pkg.sv =====
// ----------------------------------------------------------------------------
// ihsq_pkg
// Shared types, constants and helpers for the IR / home sensor qualifier.
// ----------------------------------------------------------------------------
package ihsq_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

    typedef logic [TIMER_WIDTH-1:0] timer_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_TICKS    = 2'd0,
        CFG_POLL_TICKS        = 2'd1,
        CFG_IR_ACTIVE_LEVEL   = 2'd2,
        CFG_HOME_ACTIVE_LEVEL = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic       ir_one_pin;
        logic       ir_two_pin;
        logic       home_x_pin;
        logic       home_y_pin;
        logic       ir_enable;
        logic       clear_ir;
        logic [1:0] clear_home_mask;
    } sample_t;

    typedef struct packed {
        logic ir_detected;
        logic home_x_latched;
        logic home_y_latched;
        logic ir_debouncing;
    } status_t;

    // Period limited to the timer range.
    function automatic timer_t clamp_period(input logic [CFG_WIDTH-1:0] p);
        timer_t r;
        if (32'(p) > 32'(TMAX))
            r = TMAX;
        else
            r = TIMER_WIDTH'(p);
        return r;
    endfunction

    // Saturating increment.
    function automatic timer_t advance(input timer_t c);
        timer_t r;
        if (c == TMAX)
            r = TMAX;
        else
            r = c + 1'b1;
        return r;
    endfunction

endpackage

// ===== rtl/ihsq_sample_if.sv =====
// ----------------------------------------------------------------------------
// ihsq_sample_if
// Valid/ready channel carrying one tick of sampled pins and commands.
// ----------------------------------------------------------------------------
interface ihsq_sample_if
    import ihsq_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/ihsq_status_if.sv =====
// ----------------------------------------------------------------------------
// ihsq_status_if
// Valid/ready channel carrying the latch status after one tick.
// ----------------------------------------------------------------------------
interface ihsq_status_if
    import ihsq_pkg::*;
();
    logic    valid;
    logic    ready;
    status_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/ir_home_sensor_qualifier.sv =====
// ----------------------------------------------------------------------------
// ir_home_sensor_qualifier
// Each accepted tick's status is written into the output register.
// Throughput: one tick per cycle while status.ready stays high, set by the single state update per transaction.
// Reset: rst_n async low; config to defaults, latches and debounce timer cleared,
// poll timer preset to its maximum so the first tick polls.
// ----------------------------------------------------------------------------
module ir_home_sensor_qualifier
    import ihsq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    ihsq_sample_if.sink          sample,
    ihsq_status_if.source        status
);

    // Configuration registers
    logic [CFG_WIDTH-1:0] debounce_ticks_reg;
    logic [CFG_WIDTH-1:0] poll_ticks_reg;
    logic                 ir_active_level_reg;
    logic                 home_active_level_reg;

    // Qualifier state
    logic [3:0] prev_pins_reg;      // active flags: IR1, IR2, home X, home Y
    logic       pending_reg;
    timer_t     deb_count_reg;
    timer_t     poll_count_reg;
    logic       ir_latch_reg;
    logic [1:0] home_latch_reg;     // bit0 X, bit1 Y

    // Output register
    logic       out_valid_reg;
    status_t    out_data_reg;

    logic       accept;

    logic [3:0] now_act;
    logic [3:0] rising;
    logic       pending_next;
    timer_t     deb_count_next;
    timer_t     poll_count_next;
    logic       ir_latch_next;
    logic [1:0] home_latch_next;

    // The output register frees up whenever its contents are taken, so a new
    // tick enters in the same cycle the previous status is consumed.
    assign sample.ready = !out_valid_reg || status.ready;
    assign accept       = sample.valid && sample.ready;

    assign status.valid   = out_valid_reg;
    assign status.payload = out_data_reg;

    // Active-level decode and edge detect
    always_comb
    begin
        now_act[0] = (sample.payload.ir_one_pin == ir_active_level_reg);
        now_act[1] = (sample.payload.ir_two_pin == ir_active_level_reg);
        now_act[2] = (sample.payload.home_x_pin == home_active_level_reg);
        now_act[3] = (sample.payload.home_y_pin == home_active_level_reg);
        rising     = now_act & ~prev_pins_reg;
    end

    // Per-tick update: clears, IR arm/cancel, debounce check, home edges,
    // home poll, poll counter advance.
    always_comb
    begin
        pending_next    = pending_reg && !sample.payload.clear_ir;
        ir_latch_next   = ir_latch_reg && !sample.payload.clear_ir;
        home_latch_next = home_latch_reg & ~sample.payload.clear_home_mask;
        deb_count_next  = deb_count_reg;

        if (!sample.payload.ir_enable)
        begin
            pending_next = 1'b0;
        end
        else if (rising[1:0] != 2'b00)
        begin
            pending_next   = 1'b1;
            deb_count_next = '0;
        end

        // Zero debounce re-checks in the same tick as the edge.
        if (pending_next)
        begin
            if (deb_count_next >= clamp_period(debounce_ticks_reg))
            begin
                pending_next = 1'b0;
                if (now_act[0] || now_act[1])
                    ir_latch_next = 1'b1;
            end
            else
            begin
                deb_count_next = advance(deb_count_next);
            end
        end

        home_latch_next = home_latch_next | rising[3:2];

        poll_count_next = poll_count_reg;
        if (poll_count_reg >= clamp_period(poll_ticks_reg))
        begin
            poll_count_next = '0;
            home_latch_next = home_latch_next | now_act[3:2];
        end
        poll_count_next = advance(poll_count_next);
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg    <= CFG_WIDTH'(20);
            poll_ticks_reg        <= CFG_WIDTH'(10);
            ir_active_level_reg   <= 1'b0;
            home_active_level_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEBOUNCE_TICKS:    debounce_ticks_reg    <= cfg_data;
                CFG_POLL_TICKS:        poll_ticks_reg        <= cfg_data;
                CFG_IR_ACTIVE_LEVEL:   ir_active_level_reg   <= cfg_data[0];
                CFG_HOME_ACTIVE_LEVEL: home_active_level_reg <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    // State update on each accepted transaction; first tick after reset polls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pins_reg  <= '0;
            pending_reg    <= 1'b0;
            deb_count_reg  <= '0;
            poll_count_reg <= TMAX;
            ir_latch_reg   <= 1'b0;
            home_latch_reg <= '0;
        end
        else if (accept)
        begin
            prev_pins_reg  <= now_act;
            pending_reg    <= pending_next;
            deb_count_reg  <= deb_count_next;
            poll_count_reg <= poll_count_next;
            ir_latch_reg   <= ir_latch_next;
            home_latch_reg <= home_latch_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg.ir_detected    <= ir_latch_next;
            out_data_reg.home_x_latched <= home_latch_next[0];
            out_data_reg.home_y_latched <= home_latch_next[1];
            out_data_reg.ir_debouncing  <= pending_next;
        end
    end

endmodule
